/* rtl/knob_level_with_led_curve_unit_macros.svh */
// ----------------------------------------------------------------------------
// Knob level unit assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef KNOB_LEVEL_WITH_LED_CURVE_UNIT_MACROS_SVH
`define KNOB_LEVEL_WITH_LED_CURVE_UNIT_MACROS_SVH

// Check cond in the same cycle as en.
`define KLC_ASSERT_NOW(label, en, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (en) |-> (cond)) \
    else $error(msg);

// Check cond in the cycle after en.
`define KLC_ASSERT_NEXT(label, en, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (en) |=> (cond)) \
    else $error(msg);

`endif

/* rtl/klc_pkg.sv */
// ----------------------------------------------------------------------------
// klc_pkg
// Request codes, level limits and LED curve constants for the knob level unit.
// ----------------------------------------------------------------------------
package klc_pkg;

  // Request codes
  localparam logic [3:0] REQ_KNOB    = 4'd0;
  localparam logic [3:0] REQ_ZERO    = 4'd1;
  localparam logic [3:0] REQ_ABS     = 4'd2;
  localparam logic [3:0] REQ_ADD_ARG = 4'd3;
  localparam logic [3:0] REQ_ADD_TEN = 4'd4;
  localparam logic [3:0] REQ_SUB_ARG = 4'd5;
  localparam logic [3:0] REQ_SUB_TEN = 4'd6;
  localparam logic [3:0] REQ_TOGGLE  = 4'd7;
  localparam logic [3:0] REQ_READ    = 4'd8;

  // Level limits and step sizes
  localparam logic [7:0] LEVEL_MIN = 8'd0;
  localparam logic [7:0] LEVEL_MAX = 8'd255;
  localparam logic [17:0] TEN_STEP = 18'd10;

  // Curve breakpoints on the level axis
  localparam logic [7:0] CURVE_IN_1 = 8'd50;
  localparam logic [7:0] CURVE_IN_2 = 8'd100;
  localparam logic [7:0] CURVE_IN_3 = 8'd150;
  localparam logic [7:0] CURVE_IN_4 = 8'd200;

  // Curve values at the left end of each segment
  localparam logic [7:0] CURVE_OUT_1 = 8'd20;
  localparam logic [7:0] CURVE_OUT_2 = 8'd40;
  localparam logic [7:0] CURVE_OUT_3 = 8'd100;
  localparam logic [7:0] DUTY_MAX    = 8'd254;

  // Divide by five as multiply by 205 and shift by 10 (exact below 1024)
  localparam logic [17:0] DIV5_RECIP = 18'd205;
  localparam int          DIV5_SHIFT = 10;

  // Level update result handed from the update logic to the result stage
  typedef struct packed {
    logic       report;
    logic [7:0] level;
  } klc_update_t;

endpackage

/* rtl/klc_level_update.sv */
// ----------------------------------------------------------------------------
// klc_level_update
// Next level from the current level and one request, saturated to 0..255,
// with the report flag for a change or a read.
// ----------------------------------------------------------------------------
module klc_level_update (
  input  logic [3:0]           req_type,
  input  logic signed [15:0]   argument,
  input  logic signed [7:0]    knob_steps,
  input  logic                 knob_click,
  input  logic [7:0]           cur_level,
  output klc_pkg::klc_update_t upd
);
  import klc_pkg::*;

  logic [17:0] cur_ext;
  logic [17:0] arg_ext;
  logic [17:0] steps_ext;
  logic [17:0] steps_x4;
  logic [17:0] knob_base;
  logic [17:0] sum;
  logic        is_read;
  logic [7:0]  new_level;

  // Extend operands to a common 18-bit two's complement width
  assign cur_ext   = {10'd0, cur_level};
  assign arg_ext   = {{2{argument[15]}}, argument};
  assign steps_ext = {{10{knob_steps[7]}}, knob_steps};
  assign steps_x4  = {steps_ext[15:0], 2'b00};

  // Apply the click before the steps
  always_comb begin
    if (knob_click) begin
      knob_base = (cur_level != LEVEL_MIN) ? {10'd0, LEVEL_MIN} : {10'd0, LEVEL_MAX};
    end else begin
      knob_base = cur_ext;
    end
  end

  // Select the unsaturated next level
  always_comb begin
    is_read = 1'b0;
    case (req_type)
      REQ_KNOB:    sum = knob_base + steps_x4;
      REQ_ZERO:    sum = {10'd0, LEVEL_MIN};
      REQ_ABS:     sum = arg_ext;
      REQ_ADD_ARG: sum = cur_ext + arg_ext;
      REQ_ADD_TEN: sum = cur_ext + TEN_STEP;
      REQ_SUB_ARG: sum = cur_ext - arg_ext;
      REQ_SUB_TEN: sum = cur_ext - TEN_STEP;
      REQ_TOGGLE:  sum = (cur_level != LEVEL_MAX) ? {10'd0, LEVEL_MAX} : {10'd0, LEVEL_MIN};
      REQ_READ: begin
        sum     = cur_ext;
        is_read = 1'b1;
      end
      default:     sum = cur_ext;
    endcase
  end

  // Saturate to the level range
  always_comb begin
    if (sum[17]) begin
      new_level = LEVEL_MIN;
    end else if (sum[16:8] != 9'd0) begin
      new_level = LEVEL_MAX;
    end else begin
      new_level = sum[7:0];
    end
  end

  assign upd.level  = new_level;
  assign upd.report = is_read || (new_level != cur_level);

endmodule

/* rtl/klc_duty_curve.sv */
// ----------------------------------------------------------------------------
// klc_duty_curve
// Six-point piecewise-linear LED duty curve of the level, truncating division.
// ----------------------------------------------------------------------------
module klc_duty_curve (
  input  logic [7:0] level,
  output logic [7:0] led_duty
);
  import klc_pkg::*;

  logic [7:0]  seg_ofs;
  logic [9:0]  numer;
  logic [7:0]  base;
  logic        use_div;
  logic [7:0]  direct;
  logic [17:0] prod;
  logic [7:0]  quot;

  // Pick the segment: the first three divide by 5, the rest are exact
  always_comb begin
    seg_ofs = level;
    numer   = 10'd0;
    base    = LEVEL_MIN;
    use_div = 1'b1;
    direct  = LEVEL_MIN;
    if (level < CURVE_IN_1) begin
      numer = {1'b0, level, 1'b0};
    end else if (level < CURVE_IN_2) begin
      seg_ofs = level - CURVE_IN_1;
      numer   = {1'b0, seg_ofs, 1'b0};
      base    = CURVE_OUT_1;
    end else if (level < CURVE_IN_3) begin
      seg_ofs = level - CURVE_IN_2;
      numer   = {2'b00, seg_ofs} * 10'd6;
      base    = CURVE_OUT_2;
    end else if (level <= CURVE_IN_4) begin
      seg_ofs = level - CURVE_IN_3;
      use_div = 1'b0;
      direct  = CURVE_OUT_3 + {seg_ofs[6:0], 1'b0};
    end else begin
      // Last segment: d*54/55 truncates to d-1 for d in 1..55
      use_div = 1'b0;
      direct  = level - 8'd1;
    end
  end

  // Divide by five through the reciprocal
  assign prod = {8'd0, numer} * DIV5_RECIP;
  assign quot = prod[DIV5_SHIFT +: 8];

  assign led_duty = use_div ? (base + quot) : direct;

endmodule

/* rtl/knob_level_with_led_curve_unit.sv */
// An accepted request item passes the input register, then the result register, to rsp.
// Throughput: one item per cycle; the input register and the result register
// both advance whenever the result side is free or being drained.
// Reset: rst clears the stage valids and sets the stored level to 0; no
// result is pending after reset.
`include "knob_level_with_led_curve_unit_macros.svh"
// ----------------------------------------------------------------------------
// knob_level_with_led_curve_unit
// Input register, level update with saturation and LED curve, result register.
// ----------------------------------------------------------------------------
module knob_level_with_led_curve_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [3:0]         req_type,
  input  logic signed [15:0] argument,
  input  logic signed [7:0]  knob_steps,
  input  logic               knob_click,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic               report,
  output logic [7:0]         level,
  output logic [7:0]         led_duty
);
  import klc_pkg::*;

  logic               s1_valid;
  logic [3:0]         s1_type;
  logic signed [15:0] s1_arg;
  logic signed [7:0]  s1_steps;
  logic               s1_click;
  logic [7:0]         current_level;
  logic               rsp_free;
  logic               s1_free;
  logic               s1_fire;
  klc_update_t        upd;
  logic [7:0]         duty_next;

  // Stage handshake
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign s1_free   = !s1_valid || rsp_free;
  assign s1_fire   = s1_valid && rsp_free;
  assign req_stall = !s1_free;

  // Hold the incoming item in the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && req_valid) begin
      s1_type  <= req_type;
      s1_arg   <= argument;
      s1_steps <= knob_steps;
      s1_click <= knob_click;
    end
  end

  klc_level_update u_update (
    .req_type   (s1_type),
    .argument   (s1_arg),
    .knob_steps (s1_steps),
    .knob_click (s1_click),
    .cur_level  (current_level),
    .upd        (upd)
  );

  klc_duty_curve u_curve (
    .level    (upd.level),
    .led_duty (duty_next)
  );

  // Advance the stored level with each item that moves to the result
  always_ff @(posedge clk) begin
    if (rst) begin
      current_level <= LEVEL_MIN;
    end else if (s1_fire) begin
      current_level <= upd.level;
    end
  end

  // Load the result register; drop valid once the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_free) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      report   <= upd.report;
      level    <= upd.level;
      led_duty <= duty_next;
    end
  end

  // Assertions
  `KLC_ASSERT_NOW(a_level_tracks, rsp_valid, level == current_level, "result level differs from stored level")
  `KLC_ASSERT_NOW(a_duty_range, rsp_valid, led_duty <= DUTY_MAX, "LED duty above curve maximum")
  `KLC_ASSERT_NOW(a_duty_top, rsp_valid && (level == LEVEL_MAX), led_duty == DUTY_MAX, "LED duty wrong at full level")
  `KLC_ASSERT_NEXT(a_advance, s1_fire, rsp_valid, "item lost between input and result register")

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the knob level unit. A directed table covers reset,
// saturation at both ends, every request code and unused codes 9 and 15; random
// items with idle bursts on both channels follow. Each result item is checked
// against a typed-in value or a model of the saturated level and the LED curve.
// ----------------------------------------------------------------------------
module testbench;
  import klc_pkg::*;

  // Codes the block treats as no operation
  localparam logic [3:0] REQ_UNUSED_FIRST = 4'd9;
  localparam logic [3:0] REQ_UNUSED_LAST  = 4'd15;
  localparam int         NUM_DIRECTED     = 25;
  localparam int         LONG_HOLD_CYCLES = 60;

  typedef struct packed {
    logic [3:0]  op;
    logic [15:0] arg;
    logic [7:0]  steps;
    logic        click;
  } knob_req_t;

  typedef struct packed {
    logic       report;
    logic [7:0] level;
    logic [7:0] led_duty;
  } knob_result_t;

  // One row of the directed table; typed_in selects the literal expectation
  typedef struct packed {
    knob_req_t    req;
    logic         typed_in;
    knob_result_t want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               req_valid;
  logic               req_stall;
  logic [3:0]         req_type;
  logic signed [15:0] argument;
  logic signed [7:0]  knob_steps;
  logic               knob_click;
  logic               rsp_valid;
  logic               rsp_stall;
  logic               report;
  logic [7:0]         level;
  logic [7:0]         led_duty;

  knob_result_t pending_results[$];
  stim_row_t    directed_rows[NUM_DIRECTED];
  logic [7:0]   model_level;
  int           mismatches = 0;
  int           items_sent = 0;
  int           results_checked = 0;
  int           codes_seen[16];
  bit           sender_idle = 1'b1;
  bit           receiver_idle = 1'b1;
  bit           hold_request = 1'b0;

  knob_level_with_led_curve_unit dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_type   (req_type),
    .argument   (argument),
    .knob_steps (knob_steps),
    .knob_click (knob_click),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .report     (report),
    .level      (level),
    .led_duty   (led_duty)
  );

  always #6 clk = ~clk;

  // Map a level through the six-point brightness curve, truncating
  function automatic logic [7:0] duty_curve(logic [7:0] lvl);
    int x;
    x = lvl;
    if (x <= 50) return 8'(x * 20 / 50);
    if (x <= 100) return 8'((x - 50) * 20 / 50 + 20);
    if (x <= 150) return 8'((x - 100) * 60 / 50 + 40);
    if (x <= 200) return 8'((x - 150) * 100 / 50 + 100);
    if (x < 255) return 8'((x - 200) * 54 / 55 + 200);
    return 8'd254;
  endfunction

  // Advance the model level by one item and return the result it causes
  function automatic knob_result_t step_level(knob_req_t r);
    int           cur;
    int           nxt;
    bit           is_read;
    logic [7:0]   clamped;
    knob_result_t res;
    cur = model_level;
    nxt = cur;
    is_read = 1'b0;
    case (r.op)
      REQ_KNOB: begin
        if (r.click) nxt = (cur > 0) ? 0 : 255;
        nxt += int'($signed(r.steps)) * 4;
      end
      REQ_ZERO:    nxt = 0;
      REQ_ABS:     nxt = int'($signed(r.arg));
      REQ_ADD_ARG: nxt = cur + int'($signed(r.arg));
      REQ_ADD_TEN: nxt = cur + 10;
      REQ_SUB_ARG: nxt = cur - int'($signed(r.arg));
      REQ_SUB_TEN: nxt = cur - 10;
      REQ_TOGGLE:  nxt = (cur != 255) ? 255 : 0;
      REQ_READ:    is_read = 1'b1;
      default:     nxt = cur;
    endcase
    if (nxt > 255) clamped = 8'd255;
    else if (nxt < 0) clamped = 8'd0;
    else clamped = 8'(nxt);
    res.report = is_read || (clamped != model_level);
    res.level = clamped;
    res.led_duty = duty_curve(clamped);
    model_level = clamped;
    return res;
  endfunction

  // Draw a random item, biased toward knob events and values near the limits
  function automatic knob_req_t random_request();
    knob_req_t r;
    int        pick;
    pick = $urandom_range(0, 99);
    if (pick < 7) r.op = 4'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
    else if (pick < 35) r.op = REQ_KNOB;
    else r.op = 4'($urandom_range(REQ_KNOB, REQ_READ));
    case ($urandom_range(0, 3))
      0: r.arg = 16'($urandom_range(0, 65535));
      1: r.arg = 16'($urandom_range(0, 600) - 300);
      2: begin
        case ($urandom_range(0, 5))
          0: r.arg = 16'h8000;
          1: r.arg = 16'h7fff;
          2: r.arg = 16'hffff;
          3: r.arg = 16'h0000;
          4: r.arg = 16'h00ff;
          default: r.arg = 16'h0100;
        endcase
      end
      default: r.arg = 16'($urandom_range(0, 255));
    endcase
    if ($urandom_range(0, 2) == 0) r.steps = 8'($urandom_range(0, 255));
    else r.steps = 8'($urandom_range(0, 40) - 20);
    r.click = ($urandom_range(0, 3) == 0);
    return r;
  endfunction

  // Report one mismatch and count it
  task automatic report_mismatch(string what, int got, int want);
    $display("tb: mismatch at %0t ns: %s got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Offer one item, hold it until accepted, then record its expected result
  task automatic drive_item(knob_req_t r, logic typed_in, knob_result_t want);
    int           gap;
    knob_result_t predicted;
    gap = (sender_idle && $urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid = 1'b1;
    req_type = r.op;
    argument = $signed(r.arg);
    knob_steps = $signed(r.steps);
    knob_click = r.click;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = step_level(r);
    pending_results.push_back(typed_in ? want : predicted);
    items_sent++;
    codes_seen[r.op]++;
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    rsp_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        rsp_stall = 1'b1;
        for (int c = 0; c < LONG_HOLD_CYCLES; c++) @(negedge clk);
        rsp_stall = 1'b0;
        hold_request = 1'b0;
      end else if (receiver_idle && $urandom_range(0, 6) == 0) begin
        rsp_stall = 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        rsp_stall = 1'b0;
      end else begin
        rsp_stall = 1'b0;
      end
    end
  end

  // Check each accepted result item against the oldest expectation
  always @(posedge clk) begin
    knob_result_t exp_res;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result item with nothing pending, level", level, 0);
      end else begin
        exp_res = pending_results.pop_front();
        results_checked++;
        if (report !== exp_res.report) report_mismatch("report", report, exp_res.report);
        if (level !== exp_res.level) report_mismatch("level", level, exp_res.level);
        if (led_duty !== exp_res.led_duty)
          report_mismatch("led_duty", led_duty, exp_res.led_duty);
      end
    end
  end

  // Bound the run
  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int distinct;
    rst = 1'b1;
    req_valid = 1'b0;
    req_type = REQ_KNOB;
    argument = '0;
    knob_steps = '0;
    knob_click = 1'b0;
    model_level = 8'd0;
    foreach (codes_seen[k]) codes_seen[k] = 0;

    // Directed table: op, argument, steps, click, typed-in flag, expectation
    directed_rows[0]  = '{'{REQ_READ,    16'h0000, 8'h00, 1'b0}, 1'b1, '{1'b1, 8'd0,   8'd0}};
    directed_rows[1]  = '{'{REQ_SUB_TEN, 16'h0000, 8'h00, 1'b0}, 1'b1, '{1'b0, 8'd0,   8'd0}};
    directed_rows[2]  = '{'{REQ_TOGGLE,  16'h0000, 8'h00, 1'b0}, 1'b1, '{1'b1, 8'd255, 8'd254}};
    directed_rows[3]  = '{'{REQ_ADD_TEN, 16'h0000, 8'h00, 1'b0}, 1'b1, '{1'b0, 8'd255, 8'd254}};
    directed_rows[4]  = '{'{REQ_KNOB,    16'h0000, 8'h00, 1'b1}, 1'b1, '{1'b1, 8'd0,   8'd0}};
    directed_rows[5]  = '{'{REQ_KNOB,    16'h0000, 8'h7f, 1'b1}, 1'b1, '{1'b1, 8'd255, 8'd254}};
    directed_rows[6]  = '{'{REQ_KNOB,    16'hffff, 8'h80, 1'b0}, 1'b1, '{1'b1, 8'd0,   8'd0}};
    directed_rows[7]  = '{'{REQ_ABS,     16'h7fff, 8'h00, 1'b0}, 1'b1, '{1'b1, 8'd255, 8'd254}};
    directed_rows[8]  = '{'{REQ_ABS,     16'h8000, 8'hff, 1'b1}, 1'b1, '{1'b1, 8'd0,   8'd0}};
    directed_rows[9]  = '{'{REQ_ADD_ARG, 16'h7fff, 8'h00, 1'b0}, 1'b1, '{1'b1, 8'd255, 8'd254}};
    directed_rows[10] = '{'{REQ_SUB_ARG, 16'h8000, 8'h00, 1'b0}, 1'b1, '{1'b0, 8'd255, 8'd254}};
    directed_rows[11] = '{'{REQ_SUB_ARG, 16'h7fff, 8'h00, 1'b0}, 1'b1, '{1'b1, 8'd0,   8'd0}};
    directed_rows[12] = '{'{REQ_ADD_ARG, 16'h8000, 8'h00, 1'b0}, 1'b1, '{1'b0, 8'd0,   8'd0}};
    directed_rows[13] = '{'{REQ_ABS,     16'd50,   8'h00, 1'b0}, 1'b0, '0};
    directed_rows[14] = '{'{REQ_ADD_TEN, 16'h1234, 8'h55, 1'b1}, 1'b0, '0};
    directed_rows[15] = '{'{REQ_SUB_TEN, 16'h0000, 8'h00, 1'b0}, 1'b0, '0};
    directed_rows[16] = '{'{REQ_ABS,     16'd149,  8'h00, 1'b0}, 1'b0, '0};
    directed_rows[17] = '{'{REQ_ADD_ARG, 16'd52,   8'h00, 1'b0}, 1'b0, '0};
    directed_rows[18] = '{'{REQ_ABS,     16'd254,  8'h00, 1'b0}, 1'b0, '0};
    directed_rows[19] = '{'{REQ_KNOB,    16'h0000, 8'hfe, 1'b0}, 1'b0, '0};
    directed_rows[20] = '{'{REQ_ZERO,    16'h7fff, 8'h7f, 1'b1}, 1'b1, '{1'b1, 8'd0,   8'd0}};
    directed_rows[21] = '{'{REQ_UNUSED_FIRST, 16'h00ff, 8'h05, 1'b1},
                          1'b1, '{1'b0, 8'd0, 8'd0}};
    directed_rows[22] = '{'{REQ_TOGGLE,  16'h0000, 8'h00, 1'b0}, 1'b1, '{1'b1, 8'd255, 8'd254}};
    directed_rows[23] = '{'{REQ_UNUSED_LAST, 16'hffff, 8'hff, 1'b1},
                          1'b1, '{1'b0, 8'd255, 8'd254}};
    directed_rows[24] = '{'{REQ_READ,    16'h5a5a, 8'ha5, 1'b1}, 1'b1, '{1'b1, 8'd255, 8'd254}};

    // Hold reset, then release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Walk the directed table
    for (int i = 0; i < NUM_DIRECTED; i++)
      drive_item(directed_rows[i].req, directed_rows[i].typed_in, directed_rows[i].want);

    // Random items with idle bursts on both sides
    for (int i = 0; i < 800; i++) drive_item(random_request(), 1'b0, '0);

    // Fill the pipe against a long receiver hold-off, then drain fully
    sender_idle = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 30; i++) drive_item(random_request(), 1'b0, '0);
    @(negedge clk);
    req_valid = 1'b0;
    wait (pending_results.size() == 0);
    sender_idle = 1'b1;

    for (int i = 0; i < 700; i++) drive_item(random_request(), 1'b0, '0);

    // Finish at full rate with no idling
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    for (int i = 0; i < 300; i++) drive_item(random_request(), 1'b0, '0);
    @(negedge clk);
    req_valid = 1'b0;

    wait (pending_results.size() == 0);
    repeat (10) @(posedge clk);

    distinct = 0;
    foreach (codes_seen[k]) if (codes_seen[k] > 0) distinct++;
    $display("tb: %0d items driven, %0d result items checked, %0d mismatches",
             items_sent, results_checked, mismatches);
    $display("tb: %0d of 16 request codes used, with stall bursts and one long hold-off",
             distinct);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
